// ===== hdl/rau_pkg.sv =====
// rau_pkg: shared types and constants of the rational arithmetic unit
// used by the interfaces, controller, datapath and top level
package rau_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int RES_WIDTH = 32;
  localparam int EXP_WIDTH = 8;
  localparam int MODE_WIDTH = 3;
  localparam int CNT_WIDTH = 6;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_ABS = 3'd4,
    MODE_POW = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_COMB,
    ST_POW,
    ST_RED,
    ST_GCD,
    ST_QUO,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prod;
    logic comb;
    logic pow_step;
    logic red;
    logic gcd_start;
    logic div_bit;
    logic mod_done;
    logic quo_start;
    logic quo_done;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;
    logic pow_done;
    logic num_zero;
    logic y_zero;
  } dp_sts_t;
endpackage

// ===== hdl/rau_if.sv =====
// rau_if: valid/ready channels for input items and results
// depends on rau_pkg
interface rau_in_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic [MODE_WIDTH-1:0] mode;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;
  logic signed [EXP_WIDTH-1:0] exponent;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, exponent, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, exponent, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic signed [RES_WIDTH-1:0] res_num;
  logic signed [RES_WIDTH-1:0] res_den;
  logic div_zero;
  modport source (output valid, res_num, res_den, div_zero, input ready);
  modport sink (input valid, res_num, res_den, div_zero, output ready);
endinterface

// ===== hdl/rau_ctrl.sv =====
// rau_ctrl: sequencer of the rational arithmetic unit
// depends on rau_pkg; drives rau_dp by command struct
module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::dp_cmd_t  cmd,
  input  rau_pkg::dp_sts_t  sts
);
  import rau_pkg::*;

  state_t state, state_next;
  logic [CNT_WIDTH-1:0] cnt, cnt_next;
  logic out_valid_next;

  // state, bit counter and output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        if (sts.special) state_next = ST_DONE;
        else begin
          cmd.prod = 1'b1;
          state_next = ST_COMB;
        end
      end
      ST_COMB: begin
        cmd.comb = 1'b1;
        state_next = ST_POW;
      end
      ST_POW: begin
        if (sts.pow_done) state_next = ST_RED;
        else cmd.pow_step = 1'b1;
      end
      ST_RED: begin
        cmd.red = 1'b1;
        if (sts.num_zero) state_next = ST_DONE;
        else begin
          cmd.gcd_start = 1'b1;
          state_next = ST_GCD;
        end
      end
      // one remainder bit per cycle within each euclid step
      ST_GCD: begin
        if (sts.y_zero) begin
          cmd.quo_start = 1'b1;
          cnt_next = '0;
          state_next = ST_QUO;
        end else begin
          cmd.div_bit = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == CNT_WIDTH'(RES_WIDTH - 1)) begin
            cmd.mod_done = 1'b1;
            cnt_next = '0;
          end
        end
      end
      ST_QUO: begin
        cmd.div_bit = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_WIDTH'(RES_WIDTH - 1)) begin
          cmd.quo_done = 1'b1;
          cnt_next = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== hdl/rau_dp.sv =====
// rau_dp: registers, multiplier and bit-serial divider of the unit
// depends on rau_pkg; sequenced by rau_ctrl
module rau_dp (
  input  logic                                   clk,
  input  logic [rau_pkg::MODE_WIDTH-1:0]         mode,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den,
  input  logic signed [rau_pkg::EXP_WIDTH-1:0]   exponent,
  input  rau_pkg::dp_cmd_t                       cmd,
  output rau_pkg::dp_sts_t                       sts,
  output logic [rau_pkg::RES_WIDTH-1:0]          res_num,
  output logic [rau_pkg::RES_WIDTH-1:0]          res_den,
  output logic                                   div_zero
);
  import rau_pkg::*;
  localparam int W = RES_WIDTH;

  logic [MODE_WIDTH-1:0] md;
  logic [W-1:0] an, ad, bn, bd;
  logic [EXP_WIDTH-1:0] cnt_e;
  logic [W-1:0] p0, p1, p2;
  logic [W-1:0] num, den, mn, mdn;
  logic dz, is_abs;
  // divider: x mod y, then quotient passes for num and den
  logic [W-1:0] x, y, rem, dq, nq;
  logic [W-1:0] num_mag, den_mag;
  logic num_neg, den_neg;
  logic [W:0] trial_r;
  logic [W-1:0] r_shift, src;
  logic sub_ok;
  // fraction with the sign moved off the denominator
  logic [W-1:0] num_adj, den_adj;
  // second quotient lane for the denominator
  logic [W-1:0] drem, dqq;
  logic [W:0] dtrial;
  logic [W-1:0] dshift;
  logic dok;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(0) - v : v;
  endfunction

  assign sts.special = (md == MODE_ABS) || (md > MODE_POW) || (md == MODE_DIV && bn == '0);
  assign sts.pow_done = (cnt_e == '0) || (md != MODE_POW);
  assign sts.num_zero = (num == '0);
  assign sts.y_zero = (y == '0);

  assign num_adj = den[W-1] ? W'(0) - num : num;
  assign den_adj = den[W-1] ? W'(0) - den : den;

  // one restoring step on the source shifted in from the top
  assign r_shift = {rem[W-2:0], src[W-1]};
  assign trial_r = {1'b0, r_shift} - {1'b0, y};
  assign sub_ok = !trial_r[W] || rem[W-1];

  assign dshift = {drem[W-2:0], dq[W-1]};
  assign dtrial = {1'b0, dshift} - {1'b0, y};
  assign dok = !dtrial[W] || drem[W-1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      md <= mode;
      an <= W'(a_num);
      ad <= W'(a_den);
      bn <= W'(b_num);
      bd <= W'(b_den);
      dz <= 1'b0;
      is_abs <= 1'b0;
      cnt_e <= exponent[EXP_WIDTH-1] ? EXP_WIDTH'(0) - exponent : exponent;
      mn <= exponent[EXP_WIDTH-1] ? W'(a_den) : W'(a_num);
      mdn <= exponent[EXP_WIDTH-1] ? W'(a_num) : W'(a_den);
    end
    // special results or cross products
    if (!cmd.load && !cmd.prod && !cmd.comb && !cmd.pow_step && !cmd.red
        && !cmd.div_bit && !cmd.quo_start && !cmd.out_load && sts.special) begin
      if (md == MODE_ABS) begin
        num <= mag(an); den <= mag(ad); is_abs <= 1'b1;
      end else if (md == MODE_DIV) begin
        num <= '0; den <= '0; dz <= 1'b1;
      end else begin
        num <= '0; den <= W'(1);
      end
    end
    if (cmd.prod) begin
      case (md)
        MODE_ADD, MODE_SUB: begin
          p0 <= an * bd; p1 <= ad * bn; p2 <= ad * bd;
        end
        MODE_MUL: begin p0 <= an * bn; p1 <= '0; p2 <= ad * bd; end
        MODE_DIV: begin p0 <= an * bd; p1 <= '0; p2 <= ad * bn; end
        default: begin p0 <= W'(1); p1 <= '0; p2 <= W'(1); end
      endcase
    end
    if (cmd.comb) begin
      num <= (md == MODE_SUB) ? p0 - p1 : p0 + p1;
      den <= p2;
    end
    if (cmd.pow_step) begin
      num <= num * mn;
      den <= den * mdn;
      cnt_e <= cnt_e - 1'b1;
    end
    if (cmd.red) begin
      if (num == '0) den <= W'(1);
      else if (den[W-1]) begin
        num <= W'(0) - num; den <= W'(0) - den;
      end
    end
    if (cmd.gcd_start) begin
      x <= mag(num); y <= mag(den_adj);
      num_neg <= num_adj[W-1];
      num_mag <= mag(num_adj);
      den_neg <= den_adj[W-1];
      den_mag <= mag(den_adj);
      rem <= '0; src <= mag(num);
    end
    // bit-serial x mod y, then quotients of num and den by gcd
    if (cmd.div_bit) begin
      rem <= sub_ok ? trial_r[W-1:0] : r_shift;
      nq <= {nq[W-2:0], sub_ok};
      src <= {src[W-2:0], 1'b0};
      dq <= {dq[W-2:0], 1'b0};
      if (cmd.mod_done) begin
        x <= y; y <= sub_ok ? trial_r[W-1:0] : r_shift;
        rem <= '0; src <= y;
      end
    end
    if (cmd.quo_start) begin
      y <= x; rem <= '0; src <= num_mag; dq <= den_mag;
    end
    if (cmd.quo_done) begin
      num <= num_neg ? W'(0) - {nq[W-2:0], sub_ok} : {nq[W-2:0], sub_ok};
      num_mag <= '0;
      if (!is_abs)
        den <= den_neg ? W'(0) - {dqq[W-2:0], dok} : {dqq[W-2:0], dok};
    end
    if (cmd.out_load) begin
      res_num <= num;
      res_den <= den;
      div_zero <= dz;
    end
  end

  // denominator lane shares the gcd divisor in y
  always_ff @(posedge clk) begin
    if (cmd.quo_start) drem <= '0;
    else if (cmd.div_bit) begin
      drem <= dok ? dtrial[W-1:0] : dshift;
      dqq <= {dqq[W-2:0], dok};
    end
  end
endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level of the fraction arithmetic unit
// depends on rau_pkg, rau_if, rau_ctrl, rau_dp
//
// Usage: one input channel (in) carries mode, both fractions and the
// exponent; one result channel (out) carries res_num, res_den, div_zero.
// Items are handled one at a time: in.ready is high only while idle.
// Steps: cross products, combine, in power mode one power step per unit
// of exponent magnitude (up to 128), reduction, Euclid remainder steps
// of the bit-serial divider, then the final gcd quotients.
// Absolute, divide-by-zero and unused modes skip to the output stage.
// Results sit in an output register; a stalled receiver holds the result
// and the unit waits before loading the next one.
// Reset (rst, synchronous) clears the sequencer and drops out.valid.
module rational_arithmetic_unit (
  input logic clk,
  input logic rst,
  rau_in_if.sink in,
  rau_out_if.source out
);
  import rau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .cmd(cmd), .sts(sts)
  );

  rau_dp u_dp (
    .clk(clk),
    .mode(in.mode), .a_num(in.a_num), .a_den(in.a_den),
    .b_num(in.b_num), .b_den(in.b_den), .exponent(in.exponent),
    .cmd(cmd), .sts(sts),
    .res_num(out.res_num), .res_den(out.res_den), .div_zero(out.div_zero)
  );
endmodule
